FILE: rtl/stt_pkg.sv
`default_nettype none

package stt_pkg;

    localparam int SLOTS       = 16;
    localparam int MAX_RESULTS = 16;
    localparam int SLOT_W      = $clog2(SLOTS > 1 ? SLOTS : 2);
    localparam int CNT_W       = $clog2(MAX_RESULTS + 1);
    localparam int DELAY_W     = 32;
    localparam int TAG_W       = 16;

    localparam logic ACT_TICK  = 1'b0;
    localparam logic ACT_ARM   = 1'b1;

    localparam logic KIND_ACK  = 1'b0;
    localparam logic KIND_FIRE = 1'b1;

    localparam logic STS_OK    = 1'b0;
    localparam logic STS_FULL  = 1'b1;

    typedef enum logic [1:0] {
        OP_NOP,
        OP_ARM,
        OP_FREE,
        OP_DEC
    } stt_op_t;

    typedef struct packed {
        stt_op_t             op;
        logic [SLOT_W-1:0]   idx;
        logic [DELAY_W-1:0]  delay;
        logic [TAG_W-1:0]    tag;
    } stt_slot_cmd_t;

    typedef struct packed {
        logic                busy;
        logic                zero;
        logic [TAG_W-1:0]    tag;
    } stt_slot_rd_t;

endpackage

`default_nettype wire

FILE: rtl/stt_cmd_if.sv
`default_nettype none

interface stt_cmd_if import stt_pkg::*;;
    logic               valid;
    logic               ready;
    logic               action;
    logic [DELAY_W-1:0] delay_ticks;
    logic [TAG_W-1:0]   tag;

    modport source (output valid, output action, output delay_ticks, output tag,
                    input ready);
    modport sink   (input valid, input action, input delay_ticks, input tag,
                    output ready);
endinterface

`default_nettype wire

FILE: rtl/stt_res_if.sv
`default_nettype none

interface stt_res_if import stt_pkg::*;;
    logic             valid;
    logic             ready;
    logic             kind;
    logic             status;
    logic [TAG_W-1:0] fired_tag;
    logic             last;

    modport source (output valid, output kind, output status, output fired_tag,
                    output last, input ready);
    modport sink   (input valid, input kind, input status, input fired_tag,
                    input last, output ready);
endinterface

`default_nettype wire

FILE: rtl/stt_slot_store.sv
`default_nettype none

module stt_slot_store import stt_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire stt_slot_cmd_t     cmd,
    output stt_slot_rd_t           rd,
    output logic                   full,
    output logic [SLOT_W-1:0]      free_idx
);

    logic [SLOTS-1:0]   busy_reg;
    logic [SLOTS-1:0]   busy_next;
    logic [DELAY_W-1:0] delay_reg [SLOTS];
    logic [TAG_W-1:0]   tag_reg   [SLOTS];

    always_comb
    begin
        full     = 1'b1;
        free_idx = '0;
        for (int i = SLOTS - 1; i >= 0; i--)
        begin
            if (!busy_reg[i])
            begin
                full     = 1'b0;
                free_idx = SLOT_W'(i);
            end
        end
    end

    assign rd.busy = busy_reg[cmd.idx];
    assign rd.zero = (delay_reg[cmd.idx] == '0);
    assign rd.tag  = tag_reg[cmd.idx];

    always_comb
    begin
        busy_next = busy_reg;
        case (cmd.op)
            OP_ARM:  busy_next[cmd.idx] = 1'b1;
            OP_FREE: busy_next[cmd.idx] = 1'b0;
            OP_DEC:  busy_next = busy_reg;
            OP_NOP:  busy_next = busy_reg;
            default: busy_next = busy_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
        end
    end

    // The single decrementer is shared by every slot over the scan.
    always_ff @(posedge clk)
    begin
        if (cmd.op == OP_ARM)
        begin
            delay_reg[cmd.idx] <= cmd.delay;
            tag_reg[cmd.idx]   <= cmd.tag;
        end
        else if (cmd.op == OP_DEC)
        begin
            delay_reg[cmd.idx] <= delay_reg[cmd.idx] - DELAY_W'(1);
        end
    end

endmodule

`default_nettype wire

FILE: rtl/soft_timer_table.sv
// Channel  Dir  Payload                           Role
// cmd      in   action, delay_ticks, tag          arm a timer or advance one tick
// res      out  kind, status, fired_tag, last     arm acknowledgement or fired timer
//
// An arm transfer places its acknowledgement in the output register.
// A tick makes the sequencer visit one slot per cycle, unless the scan stalls, through the
// shared compare and decrement unit, then flush the last fired result.
// A fired tag is held back one step so that the final one can carry last.
// The scan stalls on a due slot while a fired tag is already held and the output register
// is still occupied, and the flush waits for the output register in the same way.
// Reset clears all slots to free; delays and tags are not reset.
`default_nettype none

module soft_timer_table import stt_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    stt_cmd_if.sink    cmd,
    stt_res_if.source  res
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SCAN  = 2'd1;
    localparam logic [1:0] ST_FLUSH = 2'd2;

    logic [1:0]        state_reg, state_next;
    logic [SLOT_W-1:0] idx_reg, idx_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              hold_valid_reg, hold_valid_next;
    logic [TAG_W-1:0]  hold_tag_reg, hold_tag_next;

    logic              out_valid_reg, out_valid_next;
    logic              out_kind_reg, out_kind_next;
    logic              out_status_reg, out_status_next;
    logic [TAG_W-1:0]  out_tag_reg, out_tag_next;
    logic              out_last_reg, out_last_next;

    stt_slot_cmd_t     slot_cmd;
    stt_slot_rd_t      slot_rd;
    logic              full;
    logic [SLOT_W-1:0] free_idx;

    logic              out_free;
    logic              accept;
    logic              due;
    logic              step_go;

    stt_slot_store u_store
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (slot_cmd),
        .rd       (slot_rd),
        .full     (full),
        .free_idx (free_idx)
    );

    assign out_free  = !out_valid_reg || res.ready;
    assign cmd.ready = (state_reg == ST_IDLE) && out_free;
    assign accept    = cmd.valid && cmd.ready;

    assign due     = slot_rd.busy && slot_rd.zero && (cnt_reg < CNT_W'(MAX_RESULTS));
    assign step_go = !(due && hold_valid_reg && !out_free);

    always_comb
    begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        cnt_next        = cnt_reg;
        hold_valid_next = hold_valid_reg;
        hold_tag_next   = hold_tag_reg;

        out_valid_next  = out_valid_reg && !res.ready;
        out_kind_next   = out_kind_reg;
        out_status_next = out_status_reg;
        out_tag_next    = out_tag_reg;
        out_last_next   = out_last_reg;

        slot_cmd.op     = OP_NOP;
        slot_cmd.idx    = (state_reg == ST_IDLE) ? free_idx : idx_reg;
        slot_cmd.delay  = cmd.delay_ticks;
        slot_cmd.tag    = cmd.tag;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (cmd.action == ACT_ARM)
                    begin
                        slot_cmd.op     = full ? OP_NOP : OP_ARM;
                        out_valid_next  = 1'b1;
                        out_kind_next   = KIND_ACK;
                        out_status_next = full ? STS_FULL : STS_OK;
                        out_tag_next    = '0;
                        out_last_next   = 1'b1;
                    end
                    else
                    begin
                        state_next = ST_SCAN;
                        idx_next   = '0;
                        cnt_next   = '0;
                    end
                end
            end

            ST_SCAN:
            begin
                if (step_go)
                begin
                    if (due)
                    begin
                        slot_cmd.op     = OP_FREE;
                        cnt_next        = cnt_reg + CNT_W'(1);
                        hold_valid_next = 1'b1;
                        hold_tag_next   = slot_rd.tag;
                        if (hold_valid_reg)
                        begin
                            out_valid_next  = 1'b1;
                            out_kind_next   = KIND_FIRE;
                            out_status_next = STS_OK;
                            out_tag_next    = hold_tag_reg;
                            out_last_next   = 1'b0;
                        end
                    end
                    else if (slot_rd.busy && !slot_rd.zero)
                    begin
                        slot_cmd.op = OP_DEC;
                    end

                    if (idx_reg == SLOT_W'(SLOTS - 1))
                    begin
                        state_next = ST_FLUSH;
                        idx_next   = '0;
                    end
                    else
                    begin
                        idx_next = idx_reg + SLOT_W'(1);
                    end
                end
            end

            ST_FLUSH:
            begin
                if (!hold_valid_reg)
                begin
                    state_next = ST_IDLE;
                end
                else if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_kind_next   = KIND_FIRE;
                    out_status_next = STS_OK;
                    out_tag_next    = hold_tag_reg;
                    out_last_next   = 1'b1;
                    hold_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            idx_reg        <= '0;
            cnt_reg        <= '0;
            hold_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            idx_reg        <= idx_next;
            cnt_reg        <= cnt_next;
            hold_valid_reg <= hold_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hold_tag_reg   <= hold_tag_next;
        out_kind_reg   <= out_kind_next;
        out_status_reg <= out_status_next;
        out_tag_reg    <= out_tag_next;
        out_last_reg   <= out_last_next;
    end

    assign res.valid     = out_valid_reg;
    assign res.kind      = out_kind_reg;
    assign res.status    = out_status_reg;
    assign res.fired_tag = out_tag_reg;
    assign res.last      = out_last_reg;

    a_arm_ack: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (cmd.action == ACT_ARM) |=> res.valid && (res.kind == KIND_ACK) && res.last)
        else $error("arm transfer not followed by an acknowledgement");

    a_fire_ok: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && (res.kind == KIND_FIRE) |-> (res.status == STS_OK))
        else $error("fired result carries a non-zero status");

    a_hold_state: assert property (@(posedge clk) disable iff (!rst_n)
        hold_valid_reg |-> (state_reg == ST_SCAN) || (state_reg == ST_FLUSH))
        else $error("held fired tag outside a tick scan");

    a_tick_scan: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (cmd.action == ACT_TICK) |=> (state_reg == ST_SCAN) && (idx_reg == '0))
        else $error("tick transfer did not start a scan at the first slot");

endmodule

`default_nettype wire

FILE: verif/stt_checker.sv
module stt_checker import stt_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    stt_cmd_if   cmd,
    stt_res_if   res,
    output int   fail_count,
    output int   owed_count
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic             kind;
        logic             status;
        logic [TAG_W-1:0] fired_tag;
        logic             last;
    } timer_result_t;

    logic               armed     [SLOTS];
    logic [DELAY_W-1:0] remaining [SLOTS];
    logic [TAG_W-1:0]   owner_tag [SLOTS];
    timer_result_t      owed_results [$];
    int                 errors;

    task automatic flag_error(input string msg);
        $display("%0t stt_checker: %s", $time, msg);
        errors++;
    endtask

    // Works out what one accepted command makes the table answer and updates the slots.
    function automatic void run_command(input logic act, input logic [DELAY_W-1:0] dly,
                                        input logic [TAG_W-1:0] tg);
        int            free_slot;
        int            fired;
        int            i;
        timer_result_t r;
        r = '0;
        if (act == ACT_ARM)
        begin
            free_slot = -1;
            for (i = SLOTS - 1; i >= 0; i--)
            begin
                if (!armed[i])
                    free_slot = i;
            end
            r.kind = KIND_ACK;
            r.last = 1'b1;
            if (free_slot < 0)
                r.status = STS_FULL;
            else
            begin
                r.status             = STS_OK;
                armed[free_slot]     = 1'b1;
                remaining[free_slot] = dly;
                owner_tag[free_slot] = tg;
            end
            owed_results.push_back(r);
        end
        else
        begin
            fired = 0;
            for (i = 0; i < SLOTS; i++)
            begin
                if (armed[i] && remaining[i] == '0)
                begin
                    // A due slot beyond the result limit stays armed for a later tick.
                    if (fired < MAX_RESULTS)
                    begin
                        r.kind      = KIND_FIRE;
                        r.status    = STS_OK;
                        r.fired_tag = owner_tag[i];
                        r.last      = 1'b0;
                        owed_results.push_back(r);
                        armed[i] = 1'b0;
                        fired++;
                    end
                end
                else if (armed[i])
                    remaining[i] = remaining[i] - DELAY_W'(1);
            end
            if (fired > 0)
                owed_results[owed_results.size() - 1].last = 1'b1;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        timer_result_t got;
        timer_result_t want;
        int            i;
        if (!rst_n)
        begin
            for (i = 0; i < SLOTS; i++)
                armed[i] = 1'b0;
            owed_results.delete();
            errors = 0;
            fail_count <= 0;
            owed_count <= 0;
        end
        else
        begin
            if (res.valid && res.ready)
            begin
                got.kind      = res.kind;
                got.status    = res.status;
                got.fired_tag = res.fired_tag;
                got.last      = res.last;
                if (owed_results.size() == 0)
                    flag_error($sformatf("result transfer with nothing owed: kind %0d tag %h",
                                         got.kind, got.fired_tag));
                else
                begin
                    want = owed_results.pop_front();
                    if (got.kind !== want.kind)
                        flag_error($sformatf("kind %0d, wanted %0d", got.kind, want.kind));
                    if (got.status !== want.status)
                        flag_error($sformatf("status %0d, wanted %0d", got.status, want.status));
                    if (got.fired_tag !== want.fired_tag)
                        flag_error($sformatf("fired_tag %h, wanted %h",
                                             got.fired_tag, want.fired_tag));
                    if (got.last !== want.last)
                        flag_error($sformatf("last %0d, wanted %0d", got.last, want.last));
                end
            end
            if (cmd.valid && cmd.ready)
                run_command(cmd.action, cmd.delay_ticks, cmd.tag);
            fail_count <= errors;
            owed_count <= owed_results.size();
        end
    end

endmodule

FILE: verif/soft_timer_table_tb.sv
module soft_timer_table_tb import stt_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_LIMIT   = 2000;
    localparam int HOLD_CYCLES  = 400;
    localparam int HOLD_AFTER   = 60;
    localparam int RANDOM_ITEMS = 250;

    logic clk = 1'b0;
    logic rst_n;
    int   fail_count;
    int   owed_count;
    int   quiet_cycles = 0;
    bit   send_steady  = 1'b0;

    stt_cmd_if cmd_ch ();
    stt_res_if res_ch ();

    soft_timer_table dut
    (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_ch),
        .res   (res_ch)
    );

    stt_checker u_checker
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd_ch),
        .res        (res_ch),
        .fail_count (fail_count),
        .owed_count (owed_count)
    );

    always #5ns clk = ~clk;

    function automatic int idle_len(input bit steady);
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    task automatic send_cmd(input logic act, input logic [DELAY_W-1:0] dly,
                            input logic [TAG_W-1:0] tg);
        int gap;
        cmd_ch.valid       <= 1'b1;
        cmd_ch.action      <= act;
        cmd_ch.delay_ticks <= dly;
        cmd_ch.tag         <= tg;
        do
            @(posedge clk);
        while (!cmd_ch.ready);
        gap = idle_len(send_steady);
        if (gap > 0)
        begin
            cmd_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    initial
    begin
        int                 sent;
        int                 burst;
        int                 r;
        int                 k;
        logic [DELAY_W-1:0] dly;
        rst_n              <= 1'b0;
        cmd_ch.valid       <= 1'b0;
        cmd_ch.action      <= ACT_TICK;
        cmd_ch.delay_ticks <= '0;
        cmd_ch.tag         <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // An empty tick, a single expiry, then a full table with one never-ending timer.
        send_cmd(ACT_TICK, '0, '0);
        send_cmd(ACT_ARM, '0, 16'hFFFF);
        send_cmd(ACT_TICK, '0, '0);
        send_cmd(ACT_ARM, 32'hFFFF_FFFF, 16'h0000);
        send_cmd(ACT_ARM, 32'd1, 16'hA5A5);
        for (k = 0; k < 13; k++)
            send_cmd(ACT_ARM, '0, TAG_W'(16'h0100 + k));
        send_cmd(ACT_ARM, 32'd2, 16'h5A5A);
        send_cmd(ACT_ARM, '0, 16'h1234);
        repeat (3) send_cmd(ACT_TICK, '0, '0);

        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            if ($urandom_range(0, 19) == 0)
                send_steady = !send_steady;
            r = $urandom_range(0, 99);
            if (r < 40)
            begin
                burst = (r < 4) ? $urandom_range(4, 18) : 1;
                repeat (burst)
                begin
                    r   = $urandom_range(0, 99);
                    dly = (r < 70) ? $urandom_range(0, 3) :
                          (r < 98) ? $urandom_range(4, 20) : $urandom();
                    send_cmd(ACT_ARM, dly, TAG_W'($urandom_range(0, 65535)));
                end
                sent += burst;
            end
            else
            begin
                send_cmd(ACT_TICK, $urandom(), TAG_W'($urandom_range(0, 65535)));
                sent++;
            end
        end
        cmd_ch.valid <= 1'b0;

        @(posedge clk);
        while (owed_count != 0)
            @(posedge clk);
        repeat (4 * (SLOTS + 1)) @(posedge clk);
        if (fail_count == 0 && owed_count == 0)
            $display("soft_timer_table_tb: PASS");
        else
            $display("soft_timer_table_tb: FAIL");
        $finish;
    end

    // The receiver stalls at random and, once, for a long stretch so that the table backs up.
    initial
    begin
        int hold_left;
        int seen;
        bit held;
        bit recv_steady;
        hold_left   = 0;
        seen        = 0;
        held        = 1'b0;
        recv_steady = 1'b0;
        res_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (cmd_ch.valid && cmd_ch.ready)
                seen++;
            if (!held && seen >= HOLD_AFTER)
            begin
                held      = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if ($urandom_range(0, 49) == 0)
                recv_steady = !recv_steady;
            if (hold_left > 0)
            begin
                res_ch.ready <= 1'b0;
                hold_left--;
            end
            else
            begin
                res_ch.ready <= 1'b1;
                hold_left = idle_len(recv_steady);
            end
        end
    end

    // A run with no transfer on either channel for too long has hung.
    always @(posedge clk)
    begin
        if (!rst_n || (cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= IDLE_LIMIT)
        begin
            $display("soft_timer_table_tb: FAIL");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

endmodule
